// ===== rtl/ipusm_pkg.sv =====
// Shared widths, types and helper functions of the inverse perspective unit-square map.
package ipusm_pkg;

  localparam int CoefW    = 32;
  localparam int NumCoef  = 8;
  localparam int IdxW     = 3;
  localparam int AddrW    = 5;
  localparam int ProdW    = 64;
  localparam int TermW    = 65;
  localparam int MulW     = 82;
  localparam int SumW     = 84;
  localparam int MagW     = 83;
  localparam int PixW     = 16;
  localparam int QW       = 17;
  localparam int DivSteps = 17;

  localparam logic [CoefW-1:0] CoefOne  = 32'h0001_0000;
  localparam logic [CoefW-1:0] CoefZero = 32'h0000_0000;

  typedef enum logic [IdxW-1:0] {
    CoefA, CoefB, CoefC, CoefD, CoefE, CoefF, CoefG, CoefH
  } coef_idx_e;

  // Coefficient products, refreshed in the cycle after a register write.
  typedef struct packed {
    logic signed [ProdW-1:0] hd, eg, bg, ah, ae, bd, fh, ch, bf, ec, fg, cg, cd, af;
    logic signed [CoefW-1:0] a, b, d, e;
  } coef_prod_t;

  // Magnitudes handed to the divider, plus the early outside flag.
  typedef struct packed {
    logic [MagW-1:0] nx;
    logic [MagW-1:0] ny;
    logic [MagW-1:0] den;
    logic            outside;
  } div_in_t;

  function automatic logic signed [TermW-1:0] ext_prod(input logic signed [ProdW-1:0] p);
    return {p[ProdW-1], p};
  endfunction

  // A Q16.16 register lifted to Q32.32.
  function automatic logic signed [TermW-1:0] lift_coef(input logic signed [CoefW-1:0] c);
    return {{(TermW-CoefW-16){c[CoefW-1]}}, c, 16'h0000};
  endfunction

  // One restoring division step; returns {quotient bit, new remainder}.
  function automatic logic [MagW:0] div_step(input logic [MagW-1:0] rem,
                                             input logic [MagW-1:0] den,
                                             input logic            first);
    logic [MagW:0] r2;
    logic [MagW:0] diff;
    logic          ge;
    r2   = first ? {1'b0, rem} : {rem, 1'b0};
    diff = r2 - {1'b0, den};
    ge   = (r2 >= {1'b0, den});
    return {ge, (ge ? diff[MagW-1:0] : r2[MagW-1:0])};
  endfunction

endpackage

// ===== rtl/inverse_perspective_unit_square_map_unit.sv =====
// Top level of the inverse perspective map of pixel coordinates onto the unit square.
//
// Channel     Direction  Handshake                 Content
// s_axis      in         tvalid/tready             pixel_u, pixel_v
// m_axis      out        tvalid/tready             unit_x, unit_y, outside (tuser)
// apb         in/out     psel/penable/pwrite       coef_a .. coef_h at 4*index
//
// One transaction can enter every cycle unless a stall backs up to s_axis; each passes
// through six front-end stages (coefficient terms, multiplies, sums,
// magnitudes, range check) and seventeen divider stages, one quotient bit each.
// Every stage has its own valid bit and a stage loads whenever it is empty or
// its successor moves, so a stall on m_axis fills bubbles before s_axis waits.
// Reset clears the valid bits and returns the coefficients to the identity map.
// Coefficient products are registered in the cycle after an APB write.
module inverse_perspective_unit_square_map_unit
  import ipusm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,   // [15:0] pixel_u, [31:16] pixel_v
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [16:0] unit_x, [33:17] unit_y, rest zero
  output logic             m_axis_tuser_o,   // [0] outside
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [CoefW-1:0] pwdata_i,
  output logic [CoefW-1:0] prdata_o,
  output logic             pready_o
);

  coef_prod_t    coef_prod;
  div_in_t       div_in;
  logic          div_valid, div_ready;
  logic [QW-1:0] unit_x, unit_y;

  assign pready_o = 1'b1;

  ipusm_coef u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .prod_o    (coef_prod)
  );

  ipusm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .u_i     (s_axis_tdata_i[15:0]),
    .v_i     (s_axis_tdata_i[31:16]),
    .coef_i  (coef_prod),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_in)
  );

  ipusm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_valid),
    .ready_o   (div_ready),
    .data_i    (div_in),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .x_o       (unit_x),
    .y_o       (unit_y),
    .outside_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {6'b0, unit_y, unit_x};

endmodule

// ===== rtl/ipusm_coef.sv =====
// Coefficient register file with APB access and registered coefficient products.
module ipusm_coef
  import ipusm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [CoefW-1:0] pwdata_i,
  output logic [CoefW-1:0] prdata_o,
  output coef_prod_t       prod_o
);

  logic signed [CoefW-1:0] coef_q [NumCoef];
  coef_prod_t              prod_q;
  logic [IdxW-1:0]         idx;

  assign idx = paddr_i[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= CoefZero;
      end
      coef_q[CoefA] <= CoefOne;
      coef_q[CoefE] <= CoefOne;
    end else if (psel_i && penable_i && pwrite_i) begin
      coef_q[idx] <= pwdata_i;
    end
  end

  assign prdata_o = coef_q[idx];

  always_ff @(posedge clk_i) begin
    prod_q.hd <= coef_q[CoefH] * coef_q[CoefD];
    prod_q.eg <= coef_q[CoefE] * coef_q[CoefG];
    prod_q.bg <= coef_q[CoefB] * coef_q[CoefG];
    prod_q.ah <= coef_q[CoefA] * coef_q[CoefH];
    prod_q.ae <= coef_q[CoefA] * coef_q[CoefE];
    prod_q.bd <= coef_q[CoefB] * coef_q[CoefD];
    prod_q.fh <= coef_q[CoefF] * coef_q[CoefH];
    prod_q.ch <= coef_q[CoefC] * coef_q[CoefH];
    prod_q.bf <= coef_q[CoefB] * coef_q[CoefF];
    prod_q.ec <= coef_q[CoefE] * coef_q[CoefC];
    prod_q.fg <= coef_q[CoefF] * coef_q[CoefG];
    prod_q.cg <= coef_q[CoefC] * coef_q[CoefG];
    prod_q.cd <= coef_q[CoefC] * coef_q[CoefD];
    prod_q.af <= coef_q[CoefA] * coef_q[CoefF];
    prod_q.a  <= coef_q[CoefA];
    prod_q.b  <= coef_q[CoefB];
    prod_q.d  <= coef_q[CoefD];
    prod_q.e  <= coef_q[CoefE];
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/ipusm_front.sv =====
// Six-stage front end: linear forms, sums, magnitudes and range checks.
module ipusm_front
  import ipusm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [PixW-1:0] u_i,
  input  logic [PixW-1:0] v_i,
  input  coef_prod_t      coef_i,
  output logic            valid_o,
  input  logic            ready_i,
  output div_in_t         data_o
);

  logic [7:1] en;
  logic [6:1] v_q;

  logic [PixW-1:0]         u1_q, v1_q, u2_q, v2_q;
  logic signed [TermW-1:0] t2_d [9];
  logic signed [TermW-1:0] t2_q [9];
  logic signed [MulW-1:0]  m3_d [6];
  logic signed [MulW-1:0]  m3_q [6];
  logic signed [TermW-1:0] c3_q [3];
  logic signed [SumW-1:0]  s4_d [3];
  logic signed [SumW-1:0]  s4_q [3];
  logic [MagW-1:0]         mag5_d [3];
  logic [MagW-1:0]         mag5_q [3];
  logic                    bad5_d, bad5_q;
  div_in_t                 out6_d, out6_q;

  always_comb begin
    en[7] = ready_i;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[1];
  assign valid_o = v_q[6];
  assign data_o  = out6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 2: coefficient terms of the three linear forms (den, nx, ny).
  always_comb begin
    t2_d[0] = ext_prod(coef_i.hd) - ext_prod(coef_i.eg);
    t2_d[1] = ext_prod(coef_i.bg) - ext_prod(coef_i.ah);
    t2_d[2] = ext_prod(coef_i.ae) - ext_prod(coef_i.bd);
    t2_d[3] = lift_coef(coef_i.e) - ext_prod(coef_i.fh);
    t2_d[4] = ext_prod(coef_i.ch) - lift_coef(coef_i.b);
    t2_d[5] = ext_prod(coef_i.bf) - ext_prod(coef_i.ec);
    t2_d[6] = ext_prod(coef_i.fg) - lift_coef(coef_i.d);
    t2_d[7] = lift_coef(coef_i.a) - ext_prod(coef_i.cg);
    t2_d[8] = ext_prod(coef_i.cd) - ext_prod(coef_i.af);
  end

  // Stage 3: products with the pixel coordinates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_d[2*i]   = t2_q[3*i]   * $signed({1'b0, u2_q});
      m3_d[2*i+1] = t2_q[3*i+1] * $signed({1'b0, v2_q});
    end
  end

  // Stage 4: the three sums.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_d[i] = SumW'(m3_q[2*i]) + SumW'(m3_q[2*i+1]) + SumW'(c3_q[i]);
    end
  end

  // Stage 5: magnitudes and sign checks; index 0 is the denominator.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag5_d[i] = s4_q[i][SumW-1] ? MagW'(-s4_q[i]) : MagW'(s4_q[i]);
    end
    bad5_d = (s4_q[0] == '0)
          || ((s4_q[1] != '0) && (s4_q[1][SumW-1] != s4_q[0][SumW-1]))
          || ((s4_q[2] != '0) && (s4_q[2][SumW-1] != s4_q[0][SumW-1]));
  end

  // Stage 6: a quotient above one is outside the square.
  always_comb begin
    out6_d.den     = mag5_q[0];
    out6_d.nx      = mag5_q[1];
    out6_d.ny      = mag5_q[2];
    out6_d.outside = bad5_q || (mag5_q[0] < mag5_q[1]) || (mag5_q[0] < mag5_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      u1_q <= u_i;
      v1_q <= v_i;
    end
    if (en[2]) begin
      u2_q <= u1_q;
      v2_q <= v1_q;
      t2_q <= t2_d;
    end
    if (en[3]) begin
      m3_q    <= m3_d;
      c3_q[0] <= t2_q[2];
      c3_q[1] <= t2_q[5];
      c3_q[2] <= t2_q[8];
    end
    if (en[4]) s4_q <= s4_d;
    if (en[5]) begin
      mag5_q <= mag5_d;
      bad5_q <= bad5_d;
    end
    if (en[6]) out6_q <= out6_d;
  end

endmodule

// ===== rtl/ipusm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for x and y.
module ipusm_div
  import ipusm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  div_in_t       data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [QW-1:0] x_o,
  output logic [QW-1:0] y_o,
  output logic          outside_o
);

  localparam int Last = DivSteps - 1;

  logic [DivSteps:0]   en;
  logic [DivSteps-1:0] v_q;
  logic [MagW-1:0]     rx_q [DivSteps];
  logic [MagW-1:0]     ry_q [DivSteps];
  logic [MagW-1:0]     d_q  [DivSteps];
  logic [QW-1:0]       qx_q [DivSteps];
  logic [QW-1:0]       qy_q [DivSteps];
  logic [DivSteps-1:0] f_q;

  assign en[DivSteps] = ready_i;
  assign ready_o      = en[0];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [MagW-1:0] rx_in, ry_in, d_in;
    logic [QW-1:0]   qx_in, qy_in;
    logic            f_in, v_in;
    logic [MagW:0]   sx, sy;

    if (s == 0) begin : g_first
      assign rx_in = data_i.nx;
      assign ry_in = data_i.ny;
      assign d_in  = data_i.den;
      assign qx_in = '0;
      assign qy_in = '0;
      assign f_in  = data_i.outside;
      assign v_in  = valid_i;
    end else begin : g_next
      assign rx_in = rx_q[s-1];
      assign ry_in = ry_q[s-1];
      assign d_in  = d_q[s-1];
      assign qx_in = qx_q[s-1];
      assign qy_in = qy_q[s-1];
      assign f_in  = f_q[s-1];
      assign v_in  = v_q[s-1];
    end

    assign en[s] = !v_q[s] || en[s+1];
    assign sx    = div_step(rx_in, d_in, (s == 0));
    assign sy    = div_step(ry_in, d_in, (s == 0));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rx_q[s] <= sx[MagW-1:0];
        ry_q[s] <= sy[MagW-1:0];
        d_q[s]  <= d_in;
        qx_q[s] <= {qx_in[QW-2:0], sx[MagW]};
        qy_q[s] <= {qy_in[QW-2:0], sy[MagW]};
        f_q[s]  <= f_in;
      end
    end
  end

  assign valid_o   = v_q[Last];
  assign outside_o = f_q[Last];
  assign x_o       = f_q[Last] ? '0 : qx_q[Last];
  assign y_o       = f_q[Last] ? '0 : qy_q[Last];

endmodule

// ===== rtl/ipusm_checker.sv =====
// Port-level checker for the unit-square map, bound to the top level.
module ipusm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A flagged point carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 40'd0)
    else $error("outside result not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[16:0] <= 17'd65536)
    else $error("unit_x above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[33:17] <= 17'd65536)
    else $error("unit_y above one");

endmodule

bind inverse_perspective_unit_square_map_unit ipusm_checker u_ipusm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
